### rtl/wrb_pkg.sv
// Package for the weighted 3x3 RGB blur core.
// Holds the transaction record passed from front to back, register indexes and sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wrb_pkg;

  localparam int TAPS      = 9;
  localparam int PIX_BITS  = 24;
  localparam int KERN_BITS = 36;
  localparam int FW_BITS   = 11;
  localparam int FH_BITS   = 12;
  localparam int ROW_BITS  = 13;
  localparam int CFG_BITS  = 2;

  localparam logic [CFG_BITS-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CFG_BITS-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_BITS-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [KERN_BITS-1:0] KERN_RESET = 36'h100010000;
  localparam logic [FW_BITS-1:0]   FW_RESET   = 11'd1024;
  localparam logic [FH_BITS-1:0]   FH_RESET   = 12'd1024;

  typedef struct packed {
    logic [TAPS-1:0][PIX_BITS-1:0] pix;
    logic [TAPS-1:0]               mask;
    logic                          last;
  } job_t;

  typedef enum logic [0:0] {F_IDLE, F_WRITE} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_ACC, B_DIV, B_OUT} back_state_t;

endpackage
`default_nettype wire

### rtl/wrb_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wrb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/wrb_fifo.sv
// Two-entry queue of job records between the front and back parts.
// Depends on wrb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wrb_fifo import wrb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      full,
  output logic      empty
);

  job_t       entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign head  = entry[rptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### rtl/wrb_front.sv
// Front part: accepts transactions, runs line stores, window and counters,
// and queues a job for each pixel that is released. Depends on wrb_pkg, wrb_ram.
`timescale 1ns / 1ps
`default_nettype none
module wrb_front import wrb_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int WEIGHT_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 operation,
  input  wire logic [7:0]           in_red,
  input  wire logic [7:0]           in_green,
  input  wire logic [7:0]           in_blue,
  input  wire logic [KERN_BITS-1:0] kernel_weights,
  input  wire logic [FW_BITS-1:0]   frame_width,
  input  wire logic [FH_BITS-1:0]   frame_height,
  output logic                      push,
  output job_t                      push_job,
  input  wire logic                 fifo_full
);

  localparam int CW = $clog2(MAX_WIDTH);

  front_state_t state, state_next;

  logic [CW-1:0]       ic, oc;
  logic [ROW_BITS-1:0] ir, orow;
  logic [PIX_BITS-1:0] pix_q;
  logic [PIX_BITS-1:0] window [TAPS];
  logic [PIX_BITS-1:0] wn [TAPS];
  logic [PIX_BITS-1:0] upper_rd, mid_rd;

  logic [CW:0]          w_eff;
  logic [FH_BITS-1:0]   h_eff;
  logic [CW-1:0]        ic0, oc0, ic1, raddr;
  logic [ROW_BITS-1:0]  ir0, or0, ir1;
  logic [CW:0]          ic_inc, oc_inc;
  logic                 emit, last, commit, accept;
  logic [TAPS-1:0]      mask;
  logic [63:0]          kern_ext;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != F_IDLE);
  assign kern_ext = {{(64-KERN_BITS){1'b0}}, kernel_weights};

  always_comb begin
    if (frame_width == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(frame_width);
    end
    h_eff = (frame_height == '0) ? FH_BITS'(1) : frame_height;
  end

  assign raddr = ({1'b0, ic} >= w_eff) ? '0 : ic;

  wrb_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(commit), .waddr(ic0), .wdata(mid_rd),
    .re(accept), .raddr(raddr), .rdata(upper_rd)
  );

  wrb_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .we(commit), .waddr(ic0), .wdata(pix_q),
    .re(accept), .raddr(raddr), .rdata(mid_rd)
  );

  always_comb begin
    logic [ROW_BITS:0] rr;
    logic [CW+1:0]     cc;
    logic [63:0]       wt;
    if ({1'b0, ic} >= w_eff) begin
      ic0 = '0;
      ir0 = ir + ROW_BITS'(1);
    end else begin
      ic0 = ic;
      ir0 = ir;
    end
    if ({1'b0, oc} >= w_eff) begin
      oc0 = '0;
      or0 = orow + ROW_BITS'(1);
    end else begin
      oc0 = oc;
      or0 = orow;
    end
    emit   = (ir0 >= ROW_BITS'(2)) || (ir0 == ROW_BITS'(1) && ic0 != '0);
    ic_inc = {1'b0, ic0} + (CW+1)'(1);
    if (ic_inc >= w_eff) begin
      ic1 = '0;
      ir1 = ir0 + ROW_BITS'(1);
    end else begin
      ic1 = ic_inc[CW-1:0];
      ir1 = ir0;
    end
    oc_inc = {1'b0, oc0} + (CW+1)'(1);
    last   = (or0 >= ROW_BITS'(h_eff) - ROW_BITS'(1))
          && ({1'b0, oc0} >= w_eff - (CW+1)'(1));
    for (int r = 0; r < 3; r++) begin
      wn[r*3]   = window[r*3+1];
      wn[r*3+1] = window[r*3+2];
    end
    wn[2] = upper_rd;
    wn[5] = mid_rd;
    wn[8] = pix_q;
    for (int k = 0; k < TAPS; k++) begin
      wt = (kern_ext >> (WEIGHT_BITS * k)) & ((64'd1 << WEIGHT_BITS) - 64'd1);
      rr = {1'b0, or0} + (ROW_BITS+1)'(k / 3) - (ROW_BITS+1)'(1);
      cc = {2'b0, oc0} + (CW+2)'(k % 3) - (CW+2)'(1);
      mask[k] = (wt != 64'd0)
             && !((k / 3) == 0 && or0 == '0)
             && !((k % 3) == 0 && oc0 == '0)
             && (rr < (ROW_BITS+1)'(h_eff))
             && (cc < {1'b0, w_eff});
    end
    commit = (state == F_WRITE) && (!emit || !fifo_full);
    push   = commit && emit;
    for (int k = 0; k < TAPS; k++) begin
      push_job.pix[k] = wn[k];
    end
    push_job.mask = mask;
    push_job.last = last;
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (accept) state_next = F_WRITE;
      F_WRITE: if (commit) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_q <= operation ? '0 : {in_red, in_green, in_blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ic   <= '0;
      ir   <= '0;
      oc   <= '0;
      orow <= '0;
      for (int k = 0; k < TAPS; k++) begin
        window[k] <= '0;
      end
    end else if (commit) begin
      for (int k = 0; k < TAPS; k++) begin
        window[k] <= wn[k];
      end
      if (emit && last) begin
        ic   <= '0;
        ir   <= '0;
        oc   <= '0;
        orow <= '0;
      end else begin
        ic <= ic1;
        ir <= ir1;
        if (emit) begin
          if (oc_inc >= w_eff) begin
            oc   <= '0;
            orow <= or0 + ROW_BITS'(1);
          end else begin
            oc   <= oc_inc[CW-1:0];
            orow <= or0;
          end
        end else begin
          oc   <= oc0;
          orow <= or0;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/wrb_back.sv
// Back part: serial weighted tap accumulator, divider of up to eight steps, output register.
// Depends on wrb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wrb_back import wrb_pkg::*; #(
  parameter int WEIGHT_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [KERN_BITS-1:0] kernel_weights,
  input  wire job_t                 head,
  input  wire logic                 fifo_empty,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_red,
  output logic [7:0]                out_green,
  output logic [7:0]                out_blue,
  output logic                      last_of_frame
);

  localparam int WSW = WEIGHT_BITS + 4;
  localparam int SW  = 8 + WSW;
  localparam int DW  = SW + 8;

  back_state_t state, state_next;

  job_t          job;
  logic [3:0]    k;
  logic [2:0]    bitn;
  logic [SW-1:0] sum [3];
  logic [WSW-1:0] ws;
  logic [7:0]    quo [3];
  logic [WEIGHT_BITS-1:0] wt;
  logic [63:0]   kern_ext;
  logic [DW-1:0] dshift;
  logic          out_free;

  assign kern_ext = {{(64-KERN_BITS){1'b0}}, kernel_weights};
  assign wt       = WEIGHT_BITS'((kern_ext >> (WEIGHT_BITS * k)) & ((64'd1 << WEIGHT_BITS) - 64'd1));
  assign dshift   = DW'(ws) << bitn;
  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == B_IDLE) && !fifo_empty;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!fifo_empty) state_next = B_ACC;
      B_ACC:  if (k == 4'd8) state_next = B_DIV;
      B_DIV:  if (bitn == 3'd0 || ws == '0) state_next = B_OUT;
      B_OUT:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        job  <= head;
        k    <= '0;
        ws   <= '0;
        bitn <= 3'd7;
        for (int c = 0; c < 3; c++) begin
          sum[c] <= '0;
          quo[c] <= '0;
        end
      end
      B_ACC: begin
        if (job.mask[k]) begin
          for (int c = 0; c < 3; c++) begin
            sum[c] <= sum[c] + SW'(job.pix[k][16-8*c +: 8] * wt);
          end
          ws <= ws + WSW'(wt);
        end
        k <= k + 4'd1;
      end
      B_DIV: begin
        for (int c = 0; c < 3; c++) begin
          if (ws != '0 && DW'(sum[c]) >= dshift) begin
            sum[c]       <= SW'(DW'(sum[c]) - dshift);
            quo[c][bitn] <= 1'b1;
          end
        end
        bitn <= bitn - 3'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && out_free) begin
      out_red       <= quo[0];
      out_green     <= quo[1];
      out_blue      <= quo[2];
      last_of_frame <= job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### rtl/weighted_3x3_rgb_blur_core.sv
// Top level of the weighted 3x3 RGB blur: configuration registers, front, queue, back.
// Depends on wrb_pkg, wrb_front, wrb_fifo, wrb_back.
//
//  channel | handshake            | payload
//  input   | in_valid / in_stall  | operation, in_red, in_green, in_blue
//  output  | out_valid / out_stall| out_red, out_green, out_blue, last_of_frame
//  config  | cfg_write            | cfg_index, cfg_data
//
// The front reads the line stores for a transaction, then writes them, before it takes the next;
// a full queue holds it in the write state. In the back a released pixel passes through serial
// accumulation of the nine taps, up to eight divider steps, one output load; the back sets the sustained rate.
// Reset is synchronous; line stores are not cleared (unwritten entries only feed
// skipped taps). Output stall holds the result register; the queue of two jobs
// then fills and stalls the front.
`timescale 1ns / 1ps
`default_nettype none
module weighted_3x3_rgb_blur_core import wrb_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int WEIGHT_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 operation,
  input  wire logic [7:0]           in_red,
  input  wire logic [7:0]           in_green,
  input  wire logic [7:0]           in_blue,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_red,
  output logic [7:0]                out_green,
  output logic [7:0]                out_blue,
  output logic                      last_of_frame,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_BITS-1:0]  cfg_index,
  input  wire logic [KERN_BITS-1:0] cfg_data
);

  logic [KERN_BITS-1:0] kernel_weights;
  logic [FW_BITS-1:0]   frame_width;
  logic [FH_BITS-1:0]   frame_height;
  logic                 push, pop, fifo_full, fifo_empty;
  job_t                 push_job, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_weights <= KERN_RESET;
      frame_width    <= FW_RESET;
      frame_height   <= FH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KERNEL: kernel_weights <= cfg_data;
        CFG_WIDTH:  frame_width    <= cfg_data[FW_BITS-1:0];
        CFG_HEIGHT: frame_height   <= cfg_data[FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  wrb_front #(.MAX_WIDTH(MAX_WIDTH), .WEIGHT_BITS(WEIGHT_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .kernel_weights(kernel_weights), .frame_width(frame_width),
    .frame_height(frame_height), .push(push), .push_job(push_job),
    .fifo_full(fifo_full)
  );

  wrb_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job), .pop(pop),
    .head(head), .full(fifo_full), .empty(fifo_empty)
  );

  wrb_back #(.WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk(clk), .rst(rst), .kernel_weights(kernel_weights), .head(head),
    .fifo_empty(fifo_empty), .pop(pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .last_of_frame(last_of_frame)
  );

endmodule
`default_nettype wire

### rtl/wrb_checker.sv
// Port-level checks for the blur core, bound to the top level.
// Depends on weighted_3x3_rgb_blur_core.
`timescale 1ns / 1ps
`default_nettype none
module wrb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue,
  input wire logic       last_of_frame
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(last_of_frame))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("reset did not clear handshake");

endmodule

bind weighted_3x3_rgb_blur_core wrb_checker u_wrb_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_red(out_red),
  .out_green(out_green), .out_blue(out_blue), .last_of_frame(last_of_frame)
);
`default_nettype wire

### verif/tb.sv
// Testbench for weighted_3x3_rgb_blur_core: random and directed frames, with random idling
// on both sides. A scoreboard class predicts each filtered pixel.
// Depends on wrb_pkg and the RTL of the blur core.
`timescale 1ns / 1ps
module tb;
  import wrb_pkg::*;

  localparam int LINE_MAX = 1024;
  localparam int DOG_LIMIT = 20000;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_pix_t;

  class blur_scoreboard;
    logic [KERN_BITS-1:0] kernel;
    logic [FW_BITS-1:0] width_reg;
    logic [FH_BITS-1:0] height_reg;
    logic [23:0] upper_line [LINE_MAX];
    logic [23:0] middle_line [LINE_MAX];
    logic [23:0] win [3][3];
    int unsigned in_col, in_row, out_col, out_row;
    blur_pix_t pending[$];
    int fails;

    function void clear();
      kernel = KERN_RESET;
      width_reg = FW_RESET;
      height_reg = FH_RESET;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      pending.delete();
      fails = 0;
    endfunction

    function void set_reg(logic [CFG_BITS-1:0] idx, logic [KERN_BITS-1:0] val);
      case (idx)
        CFG_KERNEL: kernel = val;
        CFG_WIDTH: width_reg = val[FW_BITS-1:0];
        CFG_HEIGHT: height_reg = val[FH_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h, c, wt, rr, cc, sr, sg, sb, ws;
      logic [23:0] pix, p;
      logic release_pix;
      blur_pix_t res;
      w = (width_reg == 0) ? 1 : width_reg;
      if (w > LINE_MAX) w = LINE_MAX;
      h = (height_reg == 0) ? 1 : height_reg;
      if (in_col >= w) begin
        in_col = 0; in_row++;
      end
      if (out_col >= w) begin
        out_col = 0; out_row++;
      end
      pix = op ? 24'h0 : {r, g, b};
      c = in_col;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = upper_line[c];
      win[1][2] = middle_line[c];
      win[2][2] = pix;
      upper_line[c] = middle_line[c];
      middle_line[c] = pix;
      release_pix = in_row >= 2 || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0; in_row++;
      end
      if (!release_pix) return;
      sr = 0; sg = 0; sb = 0; ws = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          wt = 32'((kernel >> (4 * (i * 3 + j))) & 4'hF);
          if (wt == 0) continue;
          if (i == 0 && out_row == 0) continue;
          if (j == 0 && out_col == 0) continue;
          rr = out_row + i - 1;
          cc = out_col + j - 1;
          if (rr >= h || cc >= w) continue;
          p = win[i][j];
          sr += p[23:16] * wt;
          sg += p[15:8] * wt;
          sb += p[7:0] * wt;
          ws += wt;
        end
      end
      res.red = (ws == 0) ? 8'd0 : 8'(sr / ws);
      res.green = (ws == 0) ? 8'd0 : 8'(sg / ws);
      res.blue = (ws == 0) ? 8'd0 : 8'(sb / ws);
      res.last = out_row >= h - 1 && out_col >= w - 1;
      if (res.last) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0; out_row++;
        end
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic l);
      blur_pix_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transaction %h %h %h last %b", $time, r, g, b, l);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (r !== e.red) begin
        $display("%0t: out_red expected %h actual %h", $time, e.red, r);
        fails++;
      end
      if (g !== e.green) begin
        $display("%0t: out_green expected %h actual %h", $time, e.green, g);
        fails++;
      end
      if (b !== e.blue) begin
        $display("%0t: out_blue expected %h actual %h", $time, e.blue, b);
        fails++;
      end
      if (l !== e.last) begin
        $display("%0t: last_of_frame expected %b actual %b", $time, e.last, l);
        fails++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic operation = 0;
  logic [7:0] in_red = 0, in_green = 0, in_blue = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [7:0] out_red, out_green, out_blue;
  logic last_of_frame;
  logic cfg_write = 0;
  logic [CFG_BITS-1:0] cfg_index = CFG_KERNEL;
  logic [KERN_BITS-1:0] cfg_data = '0;

  blur_scoreboard sb = new();
  bit calm = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int items_sent = 0;
  int dog = 0;

  always #4 clk = ~clk;

  weighted_3x3_rgb_blur_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .last_of_frame(last_of_frame),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // receiver: checks, random stall, one long hold-off on request
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(out_red, out_green, out_blue, last_of_frame);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else if (hold_req) begin
      hold_req <= 0;
      hold_left <= 400;
      out_stall <= 1;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      dog <= 0;
    else
      dog <= dog + 1;
    if (dog >= DOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_BITS-1:0] idx, logic [KERN_BITS-1:0] val);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_write <= 0;
  endtask

  task automatic send_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    operation <= op;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, r, g, b);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [7:0] chan();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // one whole frame: W*H pixels then W+1 flushes; early flushes and noisy flush payloads
  task automatic run_frame(logic [KERN_BITS-1:0] kern, int unsigned wr, int unsigned hr,
                           int early);
    int unsigned w, h, n;
    logic op;
    write_reg(CFG_KERNEL, kern);
    write_reg(CFG_WIDTH, KERN_BITS'(wr));
    write_reg(CFG_HEIGHT, KERN_BITS'(hr));
    w = (wr == 0) ? 1 : ((wr > LINE_MAX) ? LINE_MAX : wr);
    h = (hr == 0) ? 1 : hr;
    n = w * h + w + 1;
    for (int unsigned i = 0; i < n; i++) begin
      op = (i >= w * h) ? 1'b1 : ($urandom_range(99) < early);
      send_item(op, chan(), chan(), chan());
    end
    drain();
  endtask

  function automatic logic [KERN_BITS-1:0] pick_kernel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return KERN_RESET;
      default: return {4'($urandom), 32'($urandom)};
    endcase
  endfunction

  initial begin
    int frames;
    sb.clear();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    run_frame(KERN_RESET, 3, 3, 10);
    run_frame('0, 2, 2, 0);
    run_frame('1, 1, 1, 0);
    run_frame(36'h123456789, 3, 2, 30);

    frames = 0;
    while (items_sent < 650) begin
      calm = (frames % 7 == 3);
      if (frames == 5) begin
        hold_req = 1;
        run_frame(pick_kernel(), 8, 6, 5);
      end else if ($urandom_range(9) == 0)
        run_frame(pick_kernel(), $urandom_range(9, 40), $urandom_range(1, 3), 5);
      else
        run_frame(pick_kernel(), $urandom_range(1, 8), $urandom_range(1, 6), 5);
      frames++;
    end
    calm = 0;

    run_frame(pick_kernel(), 0, 0, 0);
    run_frame(pick_kernel(), 5, 12, 5);
    run_frame('1, 1, 9, 5);

    drain();
    if (sb.fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
